// ===== src/blinkwa_pkg.sv =====
// Shared types and constants for the blink window alert block.
package blinkwa_pkg;

    // Blink class codes
    localparam logic [1:0] CLASS_LONG = 2'd2;

    // Field widths
    localparam int CLASS_W      = 2;
    localparam int BIAS_W       = 10;
    localparam int RUN_W        = 8;
    localparam int LONG_OUT_W   = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 24;

    // Configuration port
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOTAL_BIAS = 1'b0,
        REG_RUN_LIMIT  = 1'b1
    } cfg_reg_t;

    // Register reset values
    localparam logic [BIAS_W-1:0] TOTAL_BIAS_RST = 10'd180;
    localparam logic [RUN_W-1:0]  RUN_LIMIT_RST  = 8'd4;

    // Saturation value of the run counter
    localparam logic [RUN_W-1:0]  RUN_MAX        = 8'd255;

endpackage

// ===== src/blink_window_alert_core.sv =====
// Top level of the blink window alert block: ring, counters and alert rule.
// Items pass the front stage (ring read), then the back stage (update), to the result.
// Throughput: one item per cycle unless results stall; a read-first ring port per item.
// Reset (aresetn low, synchronous): pointer, fill, long and run counts cleared,
// total_bias back to 180 and run_limit to 4; ring contents are left as they are.
// No clearing pass: the fill count keeps unwritten ring entries from being used.
module blink_window_alert_core #(
    parameter int WINDOW = 180
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [blinkwa_pkg::S_TDATA_W-1:0]   s_tdata,   // [1:0] blink_class
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [blinkwa_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] alert, [8:1] long_count,
                                                           // [16:9] run_count
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [blinkwa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [blinkwa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // Room for one above a full window: a new long blink is counted before
    // the oldest one is dropped
    localparam int CNT_W = $clog2(WINDOW + 2);
    localparam int SUM_W = ((CNT_W > blinkwa_pkg::BIAS_W) ? CNT_W : blinkwa_pkg::BIAS_W) + 1;
    localparam int CMP_W = ((CNT_W + 2) > SUM_W) ? (CNT_W + 2) : SUM_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

    localparam int RUN_W = blinkwa_pkg::RUN_W;

    // Configuration registers
    logic [blinkwa_pkg::BIAS_W-1:0] total_bias_reg;
    logic [RUN_W-1:0]               run_limit_reg;

    // Front stage: ring access
    logic             ring_mem [WINDOW];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             s1_valid_reg;
    logic             s1_long_reg;
    logic             s1_full_reg;
    logic             s1_old_long_reg;
    logic [CNT_W-1:0] s1_fill_reg;

    // Back stage: counters and result
    logic [CNT_W-1:0] long_total_reg;
    logic [CNT_W-1:0] long_total_next;
    logic [RUN_W-1:0] long_run_reg;
    logic [RUN_W-1:0] long_run_next;
    logic             alert_next;
    logic [CNT_W-1:0] long_plus;
    logic [SUM_W-1:0] total_sum;
    logic [CMP_W-1:0] ratio_lhs;
    logic [CMP_W-1:0] ratio_rhs;

    logic             m_valid_reg;
    logic             m_alert_reg;
    logic [RUN_W-1:0] m_long_reg;
    logic [RUN_W-1:0] m_run_reg;

    logic             s_accept;
    logic             s1_advance;
    logic             in_long;

    // Handshake control
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;
    assign in_long    = (s_tdata[blinkwa_pkg::CLASS_W-1:0] == blinkwa_pkg::CLASS_LONG);
    assign cfg_ready  = 1'b1;

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_bias_reg <= blinkwa_pkg::TOTAL_BIAS_RST;
            run_limit_reg  <= blinkwa_pkg::RUN_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                blinkwa_pkg::REG_TOTAL_BIAS: total_bias_reg <= cfg_data;
                blinkwa_pkg::REG_RUN_LIMIT:  run_limit_reg  <= cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read the oldest entry and overwrite it with the new one
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_old_long_reg    <= ring_mem[wr_ptr_reg];
            ring_mem[wr_ptr_reg] <= in_long;
        end
    end

    // Advance pointer and fill count, hold the item for the back stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                if (fill_reg != CNT_FULL) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_long_reg <= in_long;
            s1_full_reg <= (fill_reg == CNT_FULL);
            s1_fill_reg <= (fill_reg == CNT_FULL) ? fill_reg : fill_reg + 1'b1;
        end
    end

    // Update long count and run, evaluate the alert rules
    always_comb begin
        long_plus = long_total_reg + CNT_W'(s1_long_reg);
        if (s1_full_reg && s1_old_long_reg && (long_plus != '0)) begin
            long_total_next = long_plus - 1'b1;
        end else begin
            long_total_next = long_plus;
        end

        if (!s1_long_reg) begin
            long_run_next = '0;
        end else if (long_run_reg == blinkwa_pkg::RUN_MAX) begin
            long_run_next = long_run_reg;
        end else begin
            long_run_next = long_run_reg + 1'b1;
        end

        total_sum  = SUM_W'(total_bias_reg) + SUM_W'(s1_fill_reg);
        ratio_lhs  = CMP_W'({long_total_next, 2'b00});
        ratio_rhs  = CMP_W'(total_sum);
        alert_next = (ratio_lhs > ratio_rhs) || (long_run_next >= run_limit_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_total_reg <= '0;
            long_run_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s1_advance) begin
                long_total_reg <= long_total_next;
                long_run_reg   <= long_run_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_alert_reg <= alert_next;
            m_long_reg  <= blinkwa_pkg::LONG_OUT_W'(long_total_next);
            m_run_reg   <= long_run_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_run_reg, m_long_reg, m_alert_reg};

    // Input is held back only while both stages are occupied and the output stalls
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // Long blinks never outnumber the entries held
    a_long_le_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        long_total_reg <= fill_reg)
        else $error("long count exceeds fill count");

    // A waiting result is not lost or replaced
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_tdata)))
        else $error("stalled result changed");

    // A front-stage item moves on when the output has room
    a_front_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !m_valid_reg && !s_tvalid) |=> (m_valid_reg && !s1_valid_reg))
        else $error("front stage did not drain");

endmodule
